@@ rtl/core/ksfc_pkg.sv @@
// Shared types and constants for the keyed square fill canvas core.
// Used by the front, queue, back and top level; depends on nothing.
package ksfc_pkg;

   // Coordinates and extents: corner (7 bits) plus side (8 bits) fits in 9 bits
   localparam int COORD_W     = 9;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_FILL = 1'b0,
      OP_READ = 1'b1
   } ksfc_op_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } ksfc_pixel_type;

   localparam ksfc_pixel_type WHITE_PIXEL = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};
   localparam ksfc_pixel_type BLACK_PIXEL = '{red: 8'h00, green: 8'h00, blue: 8'h00};

   // Input transaction payload
   typedef struct packed {
      logic       opcode;
      logic [6:0] pos_x;
      logic [6:0] pos_y;
      logic [7:0] side;
      logic [7:0] fill_red;
      logic [7:0] fill_green;
      logic [7:0] fill_blue;
   } ksfc_req_type;

   // Result transaction payload
   typedef struct packed {
      logic [7:0] pix_red;
      logic [7:0] pix_green;
      logic [7:0] pix_blue;
      logic [7:0] reach_x;
      logic [7:0] reach_y;
   } ksfc_rsp_type;

   // Classified command handed from front to back
   typedef struct packed {
      ksfc_op_type          op;
      logic [COORD_W-1:0]   x0;
      logic [COORD_W-1:0]   y0;
      logic [COORD_W-1:0]   x_end;
      logic [COORD_W-1:0]   y_end;
      logic                 skip;   // fill with no covered pixel, or read off canvas
      ksfc_pixel_type       color;
   } ksfc_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ksfc_qstat_type;

endpackage

@@ rtl/core/ksfc_front.sv @@
// Front end: accepts request transactions, clips squares and classifies them.
// Depends on ksfc_pkg; pushes ksfc_cmd_type into the command queue.
module ksfc_front #(
   parameter int CANVAS_SIZE = 128
) (
   input  logic                    start,
   input  ksfc_pkg::ksfc_req_type  req_item,
   input  logic                    back_clearing,
   input  ksfc_pkg::ksfc_qstat_type qstat,
   output logic                    busy,
   output logic                    push,
   output ksfc_pkg::ksfc_cmd_type  cmd
);

   // Sums never exceed 382, so clipping above 511 changes nothing
   localparam int CLIP_LIM = (CANVAS_SIZE < 511) ? CANVAS_SIZE : 511;
   localparam logic [ksfc_pkg::COORD_W-1:0] CLIP_END = ksfc_pkg::COORD_W'(CLIP_LIM);

   logic [ksfc_pkg::COORD_W-1:0] x0;
   logic [ksfc_pkg::COORD_W-1:0] y0;
   logic [ksfc_pkg::COORD_W-1:0] sum_x;
   logic [ksfc_pkg::COORD_W-1:0] sum_y;
   logic [ksfc_pkg::COORD_W-1:0] end_x;
   logic [ksfc_pkg::COORD_W-1:0] end_y;
   logic                         empty_sq;
   logic                         in_canvas;

   // Hold off new transactions while the queue is full or the canvas clears
   assign busy = qstat.full | back_clearing;
   assign push = start & ~busy;

   // Clip the square at the canvas edge
   always_comb begin
      x0        = {2'b00, req_item.pos_x};
      y0        = {2'b00, req_item.pos_y};
      sum_x     = x0 + {1'b0, req_item.side};
      sum_y     = y0 + {1'b0, req_item.side};
      end_x     = (sum_x > CLIP_END) ? CLIP_END : sum_x;
      end_y     = (sum_y > CLIP_END) ? CLIP_END : sum_y;
      empty_sq  = (x0 >= end_x) || (y0 >= end_y);
      in_canvas = (32'(req_item.pos_x) < CANVAS_SIZE) && (32'(req_item.pos_y) < CANVAS_SIZE);
   end

   // Build the command
   always_comb begin
      cmd.op          = ksfc_pkg::ksfc_op_type'(req_item.opcode);
      cmd.x0          = x0;
      cmd.y0          = y0;
      cmd.x_end       = end_x;
      cmd.y_end       = end_y;
      cmd.skip        = (req_item.opcode == ksfc_pkg::OP_READ) ? ~in_canvas : empty_sq;
      cmd.color.red   = req_item.fill_red;
      cmd.color.green = req_item.fill_green;
      cmd.color.blue  = req_item.fill_blue;
   end

endmodule

@@ rtl/core/ksfc_queue.sv @@
// Short command queue between front and back end.
// Depends on ksfc_pkg for the command and status types.
module ksfc_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  ksfc_pkg::ksfc_cmd_type   push_cmd,
   input  logic                     pop,
   output ksfc_pkg::ksfc_cmd_type   head_cmd,
   output ksfc_pkg::ksfc_qstat_type qstat
);

   localparam int PTR_W = (ksfc_pkg::QUEUE_DEPTH > 1) ? $clog2(ksfc_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(ksfc_pkg::QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ksfc_pkg::QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(ksfc_pkg::QUEUE_DEPTH - 1);

   ksfc_pkg::ksfc_cmd_type entry_ff [ksfc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign qstat.full  = (count_ff == FULL_CNT);
   assign qstat.empty = (count_ff == '0);
   assign head_cmd    = entry_ff[rd_ptr_ff];

   // Store pushed commands
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ rtl/core/ksfc_back.sv @@
// Back end: canvas memory, clearing pass, keyed fill walker, pixel read, extents.
// Depends on ksfc_pkg; pops ksfc_cmd_type from the command queue.
module ksfc_back #(
   parameter int CANVAS_SIZE = 128
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ksfc_pkg::ksfc_cmd_type   head_cmd,
   input  ksfc_pkg::ksfc_qstat_type qstat,
   output logic                     pop,
   output logic                     clearing,
   output logic                     rsp_strobe,
   output ksfc_pkg::ksfc_rsp_type   rsp_item
);

   localparam int DEPTH  = CANVAS_SIZE * CANVAS_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(CANVAS_SIZE);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_FILL,
      ST_DRAIN,
      ST_READ,
      ST_READ_WAIT
   } state_type;

   state_type                    state_ff;
   ksfc_pkg::ksfc_cmd_type       cur_ff;
   logic [ADDR_W-1:0]            clr_addr_ff;
   logic [ADDR_W-1:0]            row_base_ff;
   logic [ksfc_pkg::COORD_W-1:0] x_ff;
   logic [ksfc_pkg::COORD_W-1:0] y_ff;
   logic [ksfc_pkg::COORD_W-1:0] ext_x_ff;
   logic [ksfc_pkg::COORD_W-1:0] ext_y_ff;
   logic                         pend_ff;
   logic [ADDR_W-1:0]            pend_addr_ff;
   logic                         rsp_strobe_ff;
   ksfc_pkg::ksfc_rsp_type       rsp_item_ff;

   ksfc_pkg::ksfc_pixel_type     mem [DEPTH];
   ksfc_pkg::ksfc_pixel_type     rd_data_ff;

   logic                         rd_en;
   logic [ADDR_W-1:0]            rd_addr;
   logic                         wr_en;
   logic [ADDR_W-1:0]            wr_addr;
   ksfc_pkg::ksfc_pixel_type     wr_data;
   logic [ksfc_pkg::COORD_W-1:0] ext_x_max;
   logic [ksfc_pkg::COORD_W-1:0] ext_y_max;
   logic [ksfc_pkg::COORD_W-1:0] x_next;
   logic [ksfc_pkg::COORD_W-1:0] y_next;

   assign clearing   = (state_ff == ST_CLEAR);
   assign pop        = (state_ff == ST_IDLE) && !qstat.empty;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // Memory port control: one read and one write per cycle
   always_comb begin
      rd_en   = (state_ff == ST_FILL) || (state_ff == ST_READ);
      rd_addr = row_base_ff + ADDR_W'(y_ff);
      wr_en   = clearing || (pend_ff && (rd_data_ff == ksfc_pkg::WHITE_PIXEL));
      wr_addr = clearing ? clr_addr_ff : pend_addr_ff;
      wr_data = clearing ? ksfc_pkg::WHITE_PIXEL : cur_ff.color;
   end

   // Canvas memory with registered read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Extents after the current fill
   always_comb begin
      ext_x_max = (cur_ff.x_end > ext_x_ff) ? cur_ff.x_end : ext_x_ff;
      ext_y_max = (cur_ff.y_end > ext_y_ff) ? cur_ff.y_end : ext_y_ff;
      x_next    = x_ff + 1'b1;
      y_next    = y_ff + 1'b1;
   end

   // Sequencer with registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         ext_x_ff      <= '0;
         ext_y_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         pend_ff       <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (!qstat.empty) begin
                  cur_ff   <= head_cmd;
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               // Row base of the first column
               row_base_ff <= ADDR_W'(32'(cur_ff.x0) * CANVAS_SIZE);
               x_ff        <= cur_ff.x0;
               y_ff        <= cur_ff.y0;
               if (cur_ff.skip) begin
                  rsp_strobe_ff       <= 1'b1;
                  rsp_item_ff.pix_red   <= ksfc_pkg::BLACK_PIXEL.red;
                  rsp_item_ff.pix_green <= ksfc_pkg::BLACK_PIXEL.green;
                  rsp_item_ff.pix_blue  <= ksfc_pkg::BLACK_PIXEL.blue;
                  if (cur_ff.op == ksfc_pkg::OP_FILL) begin
                     ext_x_ff            <= ext_x_max;
                     ext_y_ff            <= ext_y_max;
                     rsp_item_ff.reach_x <= ext_x_max[7:0];
                     rsp_item_ff.reach_y <= ext_y_max[7:0];
                  end else begin
                     rsp_item_ff.reach_x <= ext_x_ff[7:0];
                     rsp_item_ff.reach_y <= ext_y_ff[7:0];
                  end
                  state_ff <= ST_IDLE;
               end else if (cur_ff.op == ksfc_pkg::OP_FILL) begin
                  state_ff <= ST_FILL;
               end else begin
                  state_ff <= ST_READ;
               end
            end
            ST_FILL: begin
               // Issue one read a cycle; the write-back follows in the next cycle
               pend_ff      <= 1'b1;
               pend_addr_ff <= rd_addr;
               if (y_next == cur_ff.y_end) begin
                  y_ff        <= cur_ff.y0;
                  x_ff        <= x_next;
                  row_base_ff <= row_base_ff + ROW_STEP;
                  if (x_next == cur_ff.x_end) begin
                     state_ff <= ST_DRAIN;
                  end
               end else begin
                  y_ff <= y_next;
               end
            end
            ST_DRAIN: begin
               rsp_strobe_ff         <= 1'b1;
               rsp_item_ff.pix_red   <= ksfc_pkg::BLACK_PIXEL.red;
               rsp_item_ff.pix_green <= ksfc_pkg::BLACK_PIXEL.green;
               rsp_item_ff.pix_blue  <= ksfc_pkg::BLACK_PIXEL.blue;
               ext_x_ff              <= ext_x_max;
               ext_y_ff              <= ext_y_max;
               rsp_item_ff.reach_x   <= ext_x_max[7:0];
               rsp_item_ff.reach_y   <= ext_y_max[7:0];
               state_ff              <= ST_IDLE;
            end
            ST_READ: begin
               state_ff <= ST_READ_WAIT;
            end
            ST_READ_WAIT: begin
               rsp_strobe_ff         <= 1'b1;
               rsp_item_ff.pix_red   <= rd_data_ff.red;
               rsp_item_ff.pix_green <= rd_data_ff.green;
               rsp_item_ff.pix_blue  <= rd_data_ff.blue;
               rsp_item_ff.reach_x   <= ext_x_ff[7:0];
               rsp_item_ff.reach_y   <= ext_y_ff[7:0];
               state_ff              <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ rtl/core/keyed_square_fill_canvas_core.sv @@
// Top level of the keyed square fill canvas core.
// Instantiates ksfc_front, ksfc_queue and ksfc_back; types from ksfc_pkg.
//
//   channel   ports                         handshake
//   request   start, busy, req_item          taken when start=1 and busy=0
//   response  rsp_strobe, rsp_item           one-cycle strobe, cannot be held off
//
// During a fill the back end walks the clipped square one canvas pixel per cycle
// through a single read port and a single write port of the canvas memory. A
// read inside the canvas passes through the setup, read and read-wait states; a
// fill that covers no pixel, or a read off the canvas, is answered from setup.
// After reset the canvas is cleared to white, with busy high throughout. Up to
// two requests queue ahead of the back end; busy rises when that queue is full.
// Results leave in request order.
module keyed_square_fill_canvas_core #(
   parameter int CANVAS_SIZE = 128
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ksfc_pkg::ksfc_req_type req_item,
   output logic                   rsp_strobe,
   output ksfc_pkg::ksfc_rsp_type rsp_item
);

   logic                     push;
   logic                     pop;
   logic                     back_clearing;
   ksfc_pkg::ksfc_cmd_type   push_cmd;
   ksfc_pkg::ksfc_cmd_type   head_cmd;
   ksfc_pkg::ksfc_qstat_type qstat;

   // Accept and classify
   ksfc_front #(
      .CANVAS_SIZE (CANVAS_SIZE)
   ) u_front (
      .start         (start),
      .req_item      (req_item),
      .back_clearing (back_clearing),
      .qstat         (qstat),
      .busy          (busy),
      .push          (push),
      .cmd           (push_cmd)
   );

   // Decouple front from back
   ksfc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .qstat    (qstat)
   );

   // Carry out fills and reads
   ksfc_back #(
      .CANVAS_SIZE (CANVAS_SIZE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .qstat      (qstat),
      .pop        (pop),
      .clearing   (back_clearing),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // No result may appear while the canvas is still being cleared
   a_no_rsp_in_clear : assert property (@(posedge clock) disable iff (reset)
      back_clearing |-> !rsp_strobe)
      else $error("response during canvas clear");

   // The front never pushes into a full queue
   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      push |-> !qstat.full)
      else $error("push into full command queue");

   // Leaving reset always starts the clearing pass
   a_clear_after_reset : assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> back_clearing)
      else $error("clearing pass missing after reset");

   // Reported extents stay within the canvas
   a_reach_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_item.reach_x) <= CANVAS_SIZE)
                  && (32'(rsp_item.reach_y) <= CANVAS_SIZE))
      else $error("extent beyond canvas size");

endmodule
